/* rtl/vlp_pkg.sv */
// vlp_pkg: shared types, constants and helper functions of the v210 line packer
// used by every module of the block but the checker, and by the channel interfaces
package vlp_pkg;

    // geometry limits
    localparam int MAX_WIDTH    = 4096;
    localparam int ALIGN_PIXELS = 48;
    localparam int MAX_PAIRS    = MAX_WIDTH / 2;
    localparam int MAX_LINES    = 4096;
    localparam int MAX_RESULTS  = 32;

    // field and counter widths
    localparam int COMP_W   = 10;
    localparam int WORD_W   = 32;
    localparam int DIM_W    = 13;
    localparam int PAIR_W   = 11;
    localparam int LINE_W   = 12;
    localparam int WIL_W    = 13;
    localparam int STRIDE_W = 12;
    localparam int RES_W    = 6;
    localparam int STORE_AW = 12;
    localparam int STORE_DW = 2 * COMP_W;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int LVL_W      = 3;

    // apb
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // clip limits
    localparam logic [COMP_W-1:0] CLIP10_LO = 10'd4;
    localparam logic [COMP_W-1:0] CLIP10_HI = 10'd1019;
    localparam logic [7:0]        CLIP8_LO  = 8'd1;
    localparam logic [7:0]        CLIP8_HI  = 8'd254;

    // chroma mode codes (code 3 is unused and behaves as 4:2:2)
    localparam logic [1:0] MODE_422  = 2'd0;
    localparam logic [1:0] MODE_420P = 2'd1;
    localparam logic [1:0] MODE_420I = 2'd2;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_SAMPLE_DEPTH = 2'd0,
        REG_CHROMA_MODE  = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } t_reg_idx;

    // configuration as seen by the datapath
    typedef struct packed {
        logic             sample_depth;
        logic [1:0]       chroma_mode;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } t_cfg;

    // one packed item handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0]   word0;
        logic [WORD_W-1:0]   word1;
        logic                two_words;
        logic                end_of_line;
        logic                end_of_frame;
        logic [STRIDE_W-1:0] stride;
    } t_cmd;

    // clip one component, 8-bit samples are moved to the top of 10 bits
    function automatic logic [COMP_W-1:0] clip_comp(input logic [COMP_W-1:0] v,
                                                     input logic eight_bit);
        logic [7:0]        v8;
        logic [COMP_W-1:0] r;
        v8 = v[7:0];
        r  = v;
        if (eight_bit) begin
            if (v8 < CLIP8_LO) v8 = CLIP8_LO;
            if (v8 > CLIP8_HI) v8 = CLIP8_HI;
            r = {v8, 2'b00};
        end else begin
            if (r < CLIP10_LO) r = CLIP10_LO;
            if (r > CLIP10_HI) r = CLIP10_HI;
        end
        return r;
    endfunction

    // pairs per line, clamped to 1..MAX_PAIRS
    function automatic logic [PAIR_W:0] line_pairs(input logic [DIM_W-1:0] fw);
        logic [PAIR_W:0] p;
        p = fw[DIM_W-1:1];
        if (p == '0) p = (PAIR_W+1)'(1);
        if (p > (PAIR_W+1)'(MAX_PAIRS)) p = (PAIR_W+1)'(MAX_PAIRS);
        return p;
    endfunction

    // lines per frame, clamped to 1..MAX_LINES
    function automatic logic [DIM_W-1:0] frame_lines(input logic [DIM_W-1:0] fh);
        logic [DIM_W-1:0] h;
        h = fh;
        if (h == '0) h = DIM_W'(1);
        if (h > DIM_W'(MAX_LINES)) h = DIM_W'(MAX_LINES);
        return h;
    endfunction

    // words per line: ceil(pairs / 24) groups of 32 words
    // ceil(p/24) = floor(floor((p+23)/8)/3), the /3 by reciprocal 171/512
    function automatic logic [STRIDE_W-1:0] stride_words(input logic [PAIR_W:0] p);
        logic [PAIR_W:0] s;
        logic [8:0]      g;
        logic [16:0]     m;
        logic [6:0]      q;
        s = p + (PAIR_W+1)'(ALIGN_PIXELS / 2 - 1);
        g = s[PAIR_W:3];
        m = 17'(g) * 17'd171;
        q = m[15:9];
        return {q, 5'b00000};
    endfunction

endpackage

/* rtl/vlp_pix_if.sv */
// vlp_pix_if: input channel carrying one 4:2:2 pixel pair per item
// depends on vlp_pkg for the component width
interface vlp_pix_if;
    logic                         valid;
    logic                         ready;
    logic [vlp_pkg::COMP_W-1:0]   luma_first;
    logic [vlp_pkg::COMP_W-1:0]   luma_second;
    logic [vlp_pkg::COMP_W-1:0]   chroma_blue;
    logic [vlp_pkg::COMP_W-1:0]   chroma_red;

    modport source (output valid, luma_first, luma_second, chroma_blue, chroma_red,
                    input ready);
    modport sink (input valid, luma_first, luma_second, chroma_blue, chroma_red,
                  output ready);
endinterface

/* rtl/vlp_word_if.sv */
// vlp_word_if: output channel carrying one packed v210 word per item
// depends on vlp_pkg for the word width
interface vlp_word_if;
    logic                         valid;
    logic                         ready;
    logic [vlp_pkg::WORD_W-1:0]   packed_word;
    logic                         last_of_line;
    logic                         last_of_frame;

    modport source (output valid, packed_word, last_of_line, last_of_frame,
                    input ready);
    modport sink (input valid, packed_word, last_of_line, last_of_frame,
                  output ready);
endinterface

/* rtl/vlp_cfg_regs.sv */
// vlp_cfg_regs: apb register file holding depth, chroma mode and frame size
// depends on vlp_pkg for the register map and the t_cfg struct
module vlp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vlp_pkg::PADDR_W-1:0]   paddr,
    input  logic [vlp_pkg::PDATA_W-1:0]   pwdata,
    output logic [vlp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output vlp_pkg::t_cfg                 o_cfg
);

    vlp_pkg::t_cfg     r_cfg;
    vlp_pkg::t_reg_idx idx;
    logic              wr;

    assign idx    = vlp_pkg::t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_depth <= 1'b0;
            r_cfg.chroma_mode  <= vlp_pkg::MODE_422;
            r_cfg.frame_width  <= vlp_pkg::DIM_W'(1920);
            r_cfg.frame_height <= vlp_pkg::DIM_W'(1080);
        end else if (wr) begin
            unique case (idx)
                vlp_pkg::REG_SAMPLE_DEPTH: r_cfg.sample_depth <= pwdata[0];
                vlp_pkg::REG_CHROMA_MODE:  r_cfg.chroma_mode  <= pwdata[1:0];
                vlp_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[vlp_pkg::DIM_W-1:0];
                vlp_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[vlp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            vlp_pkg::REG_SAMPLE_DEPTH: prdata = vlp_pkg::PDATA_W'(r_cfg.sample_depth);
            vlp_pkg::REG_CHROMA_MODE:  prdata = vlp_pkg::PDATA_W'(r_cfg.chroma_mode);
            vlp_pkg::REG_FRAME_WIDTH:  prdata = vlp_pkg::PDATA_W'(r_cfg.frame_width);
            vlp_pkg::REG_FRAME_HEIGHT: prdata = vlp_pkg::PDATA_W'(r_cfg.frame_height);
            default: prdata = '0;
        endcase
    end

endmodule

/* rtl/vlp_front.sv */
// vlp_front: accepts pixel pairs, tracks line position, runs the chroma line
// stores, clips and packs components into words; depends on vlp_pkg
module vlp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vlp_pkg::t_cfg                 i_cfg,
    input  logic [vlp_pkg::LVL_W-1:0]     i_fifo_level,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [vlp_pkg::COMP_W-1:0]    i_luma_first,
    input  logic [vlp_pkg::COMP_W-1:0]    i_luma_second,
    input  logic [vlp_pkg::COMP_W-1:0]    i_chroma_blue,
    input  logic [vlp_pkg::COMP_W-1:0]    i_chroma_red,
    output logic                          o_push,
    output vlp_pkg::t_cmd                 o_cmd
);

    localparam int CW = vlp_pkg::COMP_W;

    // line position
    logic [vlp_pkg::PAIR_W-1:0]   r_pair;
    logic [vlp_pkg::LINE_W-1:0]   r_line;
    // store clearing pass
    logic                         r_clr_active;
    logic [vlp_pkg::STORE_AW-1:0] r_clr_addr;
    // chroma line stores
    logic [vlp_pkg::STORE_DW-1:0] r_store [vlp_pkg::MAX_WIDTH];
    logic [vlp_pkg::STORE_DW-1:0] r_rd;
    // accepted item stage
    logic                         r_f1_valid;
    logic [CW-1:0]                r_f1_l0, r_f1_l1, r_f1_cb, r_f1_cr;
    logic                         r_f1_reuse, r_f1_eol, r_f1_fend;
    logic [vlp_pkg::STRIDE_W-1:0] r_f1_stride;
    // leftover components
    logic [2*CW-1:0]              r_left;
    logic [1:0]                   r_cnt;

    logic                         accept;
    logic [vlp_pkg::PAIR_W:0]     pairs;
    logic [vlp_pkg::DIM_W-1:0]    height;
    logic                         eol, fend;
    logic                         store_on, reuse_line, bank;
    logic [vlp_pkg::STORE_AW-1:0] addr, waddr;
    logic [vlp_pkg::STORE_DW-1:0] wdata;
    logic                         we, re;
    logic [CW-1:0]                cb, cr, c0, c1, c2, c3;
    logic [2*CW-1:0]              n_left;
    logic [1:0]                   n_cnt;
    vlp_pkg::t_cmd                cmd;

    // item credit: the queue must hold every item in flight
    assign o_ready = !r_clr_active &&
                     ({1'b0, i_fifo_level} + (vlp_pkg::LVL_W+1)'(r_f1_valid))
                     < (vlp_pkg::LVL_W+1)'(vlp_pkg::FIFO_DEPTH);
    assign accept  = i_valid && o_ready;

    // line geometry and chroma store selection
    always_comb begin
        pairs      = vlp_pkg::line_pairs(i_cfg.frame_width);
        height     = vlp_pkg::frame_lines(i_cfg.frame_height);
        eol        = ({1'b0, r_pair} + (vlp_pkg::PAIR_W+1)'(1)) >= pairs;
        fend       = ({1'b0, r_line} + vlp_pkg::DIM_W'(1)) >= height;
        store_on   = (i_cfg.chroma_mode == vlp_pkg::MODE_420P) ||
                     (i_cfg.chroma_mode == vlp_pkg::MODE_420I);
        reuse_line = (i_cfg.chroma_mode == vlp_pkg::MODE_420P) ? r_line[0] : r_line[1];
        bank       = (i_cfg.chroma_mode == vlp_pkg::MODE_420I) ? r_line[0] : 1'b0;
        addr       = {bank, r_pair};
        we         = r_clr_active || (accept && store_on && !reuse_line);
        re         = accept && store_on && reuse_line;
        waddr      = r_clr_active ? r_clr_addr : addr;
        wdata      = r_clr_active ? '0 : {i_chroma_red, i_chroma_blue};
    end

    // chroma line store, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= r_store[addr];
        end
    end

    // clearing pass and line position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_pair       <= '0;
            r_line       <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + vlp_pkg::STORE_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (accept) begin
                if (eol) begin
                    r_pair <= '0;
                    r_line <= fend ? '0 : r_line + vlp_pkg::LINE_W'(1);
                end else begin
                    r_pair <= r_pair + vlp_pkg::PAIR_W'(1);
                end
            end
        end
    end

    // accepted item stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_l0     <= i_luma_first;
            r_f1_l1     <= i_luma_second;
            r_f1_cb     <= i_chroma_blue;
            r_f1_cr     <= i_chroma_red;
            r_f1_reuse  <= store_on && reuse_line;
            r_f1_eol    <= eol;
            r_f1_fend   <= fend;
            r_f1_stride <= vlp_pkg::stride_words(pairs);
        end
    end

    // clip and pack against the leftover components
    always_comb begin
        cb = r_f1_reuse ? r_rd[CW-1:0]    : r_f1_cb;
        cr = r_f1_reuse ? r_rd[2*CW-1:CW] : r_f1_cr;
        c0 = vlp_pkg::clip_comp(cb, i_cfg.sample_depth);
        c1 = vlp_pkg::clip_comp(r_f1_l0, i_cfg.sample_depth);
        c2 = vlp_pkg::clip_comp(cr, i_cfg.sample_depth);
        c3 = vlp_pkg::clip_comp(r_f1_l1, i_cfg.sample_depth);

        cmd.end_of_line  = r_f1_eol;
        cmd.end_of_frame = r_f1_fend;
        cmd.stride       = r_f1_stride;
        case (r_cnt)
            2'd0: begin
                cmd.word0     = {2'b00, c2, c1, c0};
                cmd.word1     = {22'd0, c3};
                cmd.two_words = r_f1_eol;
                n_left        = {{CW{1'b0}}, c3};
                n_cnt         = 2'd1;
            end
            2'd1: begin
                cmd.word0     = {2'b00, c1, c0, r_left[CW-1:0]};
                cmd.word1     = {12'd0, c3, c2};
                cmd.two_words = r_f1_eol;
                n_left        = {c3, c2};
                n_cnt         = 2'd2;
            end
            default: begin
                cmd.word0     = {2'b00, c0, r_left};
                cmd.word1     = {2'b00, c3, c2, c1};
                cmd.two_words = 1'b1;
                n_left        = '0;
                n_cnt         = 2'd0;
            end
        endcase
    end

    // leftover register, cleared at the end of each line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_cnt  <= '0;
        end else if (r_f1_valid) begin
            r_left <= r_f1_eol ? '0 : n_left;
            r_cnt  <= r_f1_eol ? '0 : n_cnt;
        end
    end

    assign o_push = r_f1_valid;
    assign o_cmd  = cmd;

endmodule

/* rtl/vlp_fifo.sv */
// vlp_fifo: short queue of packed items between the front and the back
// depends on vlp_pkg for the t_cmd entry and the depth
module vlp_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  vlp_pkg::t_cmd                 i_cmd,
    input  logic                          i_pop,
    output vlp_pkg::t_cmd                 o_head,
    output logic                          o_not_empty,
    output logic [vlp_pkg::LVL_W-1:0]     o_level
);

    vlp_pkg::t_cmd               r_mem [vlp_pkg::FIFO_DEPTH];
    logic [vlp_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [vlp_pkg::LVL_W-1:0]   r_level;
    logic                        pop;

    assign pop         = i_pop && (r_level != '0);
    assign o_head      = r_mem[r_rp];
    assign o_not_empty = (r_level != '0);
    assign o_level     = r_level;

    // entry storage, the front never pushes into a full queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + vlp_pkg::FIFO_AW'(1);
            if (pop)    r_rp <= r_rp + vlp_pkg::FIFO_AW'(1);
            r_level <= r_level + vlp_pkg::LVL_W'(i_push) - vlp_pkg::LVL_W'(pop);
        end
    end

endmodule

/* rtl/vlp_back.sv */
// vlp_back: issues the packed words of each item and the end-of-line padding,
// marks line and frame ends, holds the output register; depends on vlp_pkg
module vlp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vlp_pkg::t_cmd                 i_head,
    input  logic                          i_have,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vlp_pkg::WORD_W-1:0]    o_packed_word,
    output logic                          o_last_of_line,
    output logic                          o_last_of_frame
);

    // word sequencing state
    logic                          r_sel;
    logic                          r_pad;
    logic [vlp_pkg::RES_W-1:0]     r_n;
    logic [vlp_pkg::WIL_W-1:0]     r_wil;
    // output register
    logic                          r_valid;
    logic [vlp_pkg::WORD_W-1:0]    r_word;
    logic                          r_lol, r_lof;

    logic                          take, more_pad, last_data;
    logic [vlp_pkg::WIL_W-1:0]     wil_nx;
    logic [vlp_pkg::RES_W-1:0]     n_nx;
    logic [vlp_pkg::WORD_W-1:0]    word;
    logic                          lol, lof, done;
    logic                          n_sel, n_pad;
    logic [vlp_pkg::RES_W-1:0]     n_n;
    logic [vlp_pkg::WIL_W-1:0]     n_wil;

    assign take = i_have && (!r_valid || i_ready);

    // next word of the head item
    always_comb begin
        wil_nx    = r_wil + vlp_pkg::WIL_W'(1);
        n_nx      = r_n + vlp_pkg::RES_W'(1);
        more_pad  = (wil_nx < vlp_pkg::WIL_W'(i_head.stride)) &&
                    (n_nx < vlp_pkg::RES_W'(vlp_pkg::MAX_RESULTS));
        last_data = r_sel || !i_head.two_words;
        word      = '0;
        lol       = 1'b0;
        lof       = 1'b0;
        done      = 1'b0;
        n_sel     = r_sel;
        n_pad     = r_pad;
        if (!r_pad) begin
            word = r_sel ? i_head.word1 : i_head.word0;
            if (!last_data) begin
                n_sel = 1'b1;
            end else if (i_head.end_of_line && more_pad) begin
                n_pad = 1'b1;
            end else begin
                done = 1'b1;
                lol  = i_head.end_of_line;
                lof  = i_head.end_of_line && i_head.end_of_frame;
            end
        end else if (!more_pad) begin
            done = 1'b1;
            lol  = 1'b1;
            lof  = i_head.end_of_frame;
        end
        if (done) begin
            n_sel = 1'b0;
            n_pad = 1'b0;
            n_n   = '0;
            n_wil = i_head.end_of_line ? '0 : wil_nx;
        end else begin
            n_n   = n_nx;
            n_wil = wil_nx;
        end
    end

    assign o_pop = take && done;

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_pad <= 1'b0;
            r_n   <= '0;
            r_wil <= '0;
        end else if (take) begin
            r_sel <= n_sel;
            r_pad <= n_pad;
            r_n   <= n_n;
            r_wil <= n_wil;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= word;
            r_lol  <= lol;
            r_lof  <= lof;
        end
    end

    assign o_valid         = r_valid;
    assign o_packed_word   = r_word;
    assign o_last_of_line  = r_lol;
    assign o_last_of_frame = r_lof;

endmodule

/* rtl/v210_line_packer_unit.sv */
// v210_line_packer_unit: a pair passes the accepted item stage, the item queue
// and the output register before its first word leaves. new pairs are accepted
// while the item queue has room; the one-word output port limits the flow, as a
// line makes 4 words per 3 pairs and, at its end, any padding words to the stride.
// after reset a pass over all 4096 entries clears the chroma line stores; no pair is
// accepted during it, register writes are taken as ever
module v210_line_packer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vlp_pix_if.sink                       i_pix,
    vlp_word_if.source                    o_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vlp_pkg::PADDR_W-1:0]   paddr,
    input  logic [vlp_pkg::PDATA_W-1:0]   pwdata,
    output logic [vlp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    vlp_pkg::t_cfg               cfg;
    vlp_pkg::t_cmd               push_cmd, head;
    logic                        push, pop, have;
    logic [vlp_pkg::LVL_W-1:0]   level;

    // configuration registers
    vlp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // accept, chroma stores, clip and pack
    vlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_fifo_level  (level),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_luma_first  (i_pix.luma_first),
        .i_luma_second (i_pix.luma_second),
        .i_chroma_blue (i_pix.chroma_blue),
        .i_chroma_red  (i_pix.chroma_red),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // item queue
    vlp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (have),
        .o_level     (level)
    );

    // word issue and padding
    vlp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_have          (have),
        .o_pop           (pop),
        .o_valid         (o_word.valid),
        .i_ready         (o_word.ready),
        .o_packed_word   (o_word.packed_word),
        .o_last_of_line  (o_word.last_of_line),
        .o_last_of_frame (o_word.last_of_frame)
    );

endmodule

/* rtl/vlp_checker.sv */
// vlp_checker: port-level assertions for the v210 line packer
// bound to v210_line_packer_unit below; no package dependency
module vlp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic        i_out_lol,
    input logic        i_out_lof
);

    // a stalled word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("output word changed while stalled");

    // the store clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input accepted during store clearing");

    // nothing leaves right after reset
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a frame end is always a line end
    a_frame_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_lof |-> i_out_lol)
        else $error("frame end without line end");

    // three 10-bit components never reach the top two bits
    a_top_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word[31:30] == 2'b00)
        else $error("packed word top bits set");

endmodule

bind v210_line_packer_unit vlp_checker u_vlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_word.valid),
    .i_out_ready (o_word.ready),
    .i_out_word  (o_word.packed_word),
    .i_out_lol   (o_word.last_of_line),
    .i_out_lof   (o_word.last_of_frame)
);

/* dv/v210_line_packer_unit_tb.sv */
// v210_line_packer_unit_tb: self-checking bench for the v210 line packer
// drives pixel pairs and apb register writes, predicts every packed word in-bench
// depends on vlp_pkg, vlp_pix_if, vlp_word_if and v210_line_packer_unit
`timescale 1ns / 100ps

module v210_line_packer_unit_tb;
    import vlp_pkg::*;

    localparam int          RANDOM_ITEMS = 150;
    localparam int          QUIET_ITEMS  = 40;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          DIR_ROWS     = 38;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    // one expected output word
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              lol;
        logic              lof;
    } v210_word_t;

    // one row of the directed stimulus: a pixel pair or a register write
    typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;
    typedef struct packed {
        row_kind_t         kind;
        t_reg_idx          reg_idx;
        logic [31:0]       reg_val;
        logic [COMP_W-1:0] y0;
        logic [COMP_W-1:0] y1;
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
        logic              typed;
        logic [WORD_W-1:0] typed_word;
    } row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    vlp_pix_if  pix_ch ();
    vlp_word_if word_ch ();

    v210_line_packer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_word  (word_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic              cfg_depth;
    logic [1:0]        cfg_mode;
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;

    // predictor copy of the packing state
    logic [STORE_DW-1:0] pend_acc;
    int unsigned         pend_cnt;
    logic [PAIR_W-1:0]   pair_idx;
    logic [WIL_W-1:0]    words_in_line;
    logic [LINE_W-1:0]   line_idx;
    logic [STORE_DW-1:0] chroma_store [0:MAX_WIDTH-1];

    // words made by the pair being predicted
    logic [WORD_W-1:0]   step_word [0:MAX_RESULTS-1];
    int                  step_n;

    v210_word_t          pending_words [$];
    row_t                dir_rows [0:DIR_ROWS-1];

    logic                quiet;
    logic                cur_typed;
    logic [WORD_W-1:0]   cur_typed_word;
    int                  err_count;
    int                  cycle_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR t=%0t %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // clip one sample for the current depth, 8-bit samples land in the top bits
    function automatic logic [COMP_W-1:0] clip_sample(input logic [COMP_W-1:0] v);
        logic [7:0]        v8;
        logic [COMP_W-1:0] r;
        v8 = v[7:0];
        r  = v;
        if (cfg_depth) begin
            if (v8 < 8'd1) v8 = 8'd1;
            if (v8 > 8'd254) v8 = 8'd254;
            r = {v8, 2'b00};
        end else begin
            if (r < 10'd4) r = 10'd4;
            if (r > 10'd1019) r = 10'd1019;
        end
        return r;
    endfunction

    // append a word to this pair's output, capped at the per-pair maximum
    task automatic emit_word(input logic [WORD_W-1:0] w);
        if (step_n < MAX_RESULTS) begin
            step_word[step_n] = w;
            step_n++;
            words_in_line = words_in_line + 1'b1;
        end
    endtask

    // predict the words caused by one accepted pixel pair
    task automatic pack_pair(input logic [COMP_W-1:0] y0, y1, cb_in, cr_in,
                             input logic typed, input logic [WORD_W-1:0] typed_word);
        int unsigned       pairs, height, stride, idx, i;
        logic [COMP_W-1:0] cb, cr;
        logic [COMP_W-1:0] comps [0:3];
        logic [31:0]       acc;
        logic              reuse, bank, line_end, frame_end;
        v210_word_t        entry;
        pairs = cfg_width >> 1;
        if (pairs < 1) pairs = 1;
        if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
        height = cfg_height;
        if (height < 1) height = 1;
        if (height > MAX_LINES) height = MAX_LINES;
        cb = cb_in;
        cr = cr_in;

        // 4:2:0 chroma goes through the line stores
        if (cfg_mode == MODE_420P || cfg_mode == MODE_420I) begin
            if (cfg_mode == MODE_420P) begin
                reuse = line_idx[0];
                bank  = 1'b0;
            end else begin
                reuse = line_idx[1];
                bank  = line_idx[0];
            end
            idx = bank * MAX_PAIRS + pair_idx;
            if (reuse) begin
                cb = chroma_store[idx][COMP_W-1:0];
                cr = chroma_store[idx][STORE_DW-1:COMP_W];
            end else begin
                chroma_store[idx] = {cr, cb};
            end
        end

        comps[0] = clip_sample(cb);
        comps[1] = clip_sample(y0);
        comps[2] = clip_sample(cr);
        comps[3] = clip_sample(y1);

        // three components per word, low bits first
        step_n = 0;
        acc = 32'(pend_acc);
        for (i = 0; i < 4; i++) begin
            acc = acc | (32'(comps[i]) << (10 * pend_cnt));
            pend_cnt++;
            if (pend_cnt == 3) begin
                emit_word(acc);
                acc = '0;
                pend_cnt = 0;
            end
        end

        // end of line: flush, pad to the stride, advance the line
        line_end  = (int'(pair_idx) + 1 >= pairs);
        frame_end = 1'b0;
        if (line_end) begin
            stride    = ((pairs * 2 + ALIGN_PIXELS - 1) / ALIGN_PIXELS) * 32;
            frame_end = (int'(line_idx) + 1 >= height);
            if (pend_cnt > 0) emit_word(acc);
            while (words_in_line < stride && step_n < MAX_RESULTS) emit_word('0);
            line_idx      = frame_end ? '0 : line_idx + 1'b1;
            pair_idx      = '0;
            words_in_line = '0;
            pend_acc      = '0;
            pend_cnt      = 0;
        end else begin
            pair_idx = pair_idx + 1'b1;
            pend_acc = acc[STORE_DW-1:0];
        end

        if (typed) step_word[0] = typed_word;
        for (i = 0; i < step_n; i++) begin
            entry.word = step_word[i];
            entry.lol  = line_end && (i == step_n - 1);
            entry.lof  = frame_end && (i == step_n - 1);
            pending_words.push_back(entry);
        end
    endtask

    // apb write once the block has drained, then read the register back
    task automatic write_reg_idle(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] rd, want;
        pix_ch.valid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SAMPLE_DEPTH: begin
                cfg_depth = val[0];
                want = 32'(val[0]);
            end
            REG_CHROMA_MODE: begin
                cfg_mode = val[1:0];
                want = 32'(val[1:0]);
            end
            REG_FRAME_WIDTH: begin
                cfg_width = val[DIM_W-1:0];
                want = 32'(val[DIM_W-1:0]);
            end
            default: begin
                cfg_height = val[DIM_W-1:0];
                want = 32'(val[DIM_W-1:0]);
            end
        endcase
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== want) report_mismatch("register readback", rd, want);
    endtask

    // present one pixel pair, with an occasional gap before it
    task automatic send_pair(input logic [COMP_W-1:0] y0, y1, cb, cr,
                             input logic typed, input logic [WORD_W-1:0] typed_word);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.luma_first  = y0;
        pix_ch.luma_second = y1;
        pix_ch.chroma_blue = cb;
        pix_ch.chroma_red  = cr;
        cur_typed          = typed;
        cur_typed_word     = typed_word;
        pix_ch.valid       = 1'b1;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sample value weighted toward the clip limits of both depths
    function automatic logic [COMP_W-1:0] rand_sample();
        logic [7:0] low8;
        low8 = ($urandom_range(0, 1) != 0) ? 8'hFF - 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: return COMP_W'($urandom_range(0, 5));
            1: return COMP_W'($urandom_range(1018, 1023));
            2: return {2'($urandom_range(0, 3)), low8};
            default: return COMP_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // new settings for a random phase, mostly short lines and frames
    task automatic reconfigure_random();
        logic [31:0] val;
        if ($urandom_range(0, 1) != 0)
            write_reg_idle(REG_SAMPLE_DEPTH, 32'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 3))
                0: val = 32'(MODE_422);
                1: val = 32'(MODE_420P);
                2: val = 32'(MODE_420I);
                default: val = 32'(MODE_UNUSED);
            endcase
            write_reg_idle(REG_CHROMA_MODE, val);
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 19))
                0: val = $urandom_range(0, 1);
                1: val = 32'h1FFF;
                2: val = MAX_WIDTH;
                3: val = ALIGN_PIXELS * $urandom_range(1, 2);
                default: val = $urandom_range(2, 80);
            endcase
            write_reg_idle(REG_FRAME_WIDTH, val);
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 15))
                0: val = 0;
                1: val = 32'h1FFF;
                2: val = MAX_LINES;
                default: val = $urandom_range(1, 5);
            endcase
            write_reg_idle(REG_FRAME_HEIGHT, val);
        end
    endtask

    function automatic row_t pair_row(input logic [COMP_W-1:0] y0, y1, cb, cr,
                                      input logic typed, input logic [WORD_W-1:0] tw);
        row_t r;
        r            = '0;
        r.kind       = ROW_PAIR;
        r.y0         = y0;
        r.y1         = y1;
        r.cb         = cb;
        r.cr         = cr;
        r.typed      = typed;
        r.typed_word = tw;
        return r;
    endfunction

    function automatic row_t reg_row(input t_reg_idx idx, input logic [31:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("v210_line_packer_unit: mismatch");
            $finish;
        end
    end

    // output side backpressure in bursts, none in the quiet tail
    initial begin
        int r;
        word_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 15);
            if (!quiet && r < 2) begin
                word_ch.ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else if (r == 2) begin
                word_ch.ready = 1'b1;
                repeat ($urandom_range(16, 64) - 1) @(negedge i_clk);
            end else begin
                word_ch.ready = 1'b1;
            end
        end
    end

    // predict on every accepted pair, check every accepted word
    always @(posedge i_clk) begin
        v210_word_t want;
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready)
                pack_pair(pix_ch.luma_first, pix_ch.luma_second, pix_ch.chroma_blue,
                          pix_ch.chroma_red, cur_typed, cur_typed_word);
            if (word_ch.valid && word_ch.ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("word with nothing expected", word_ch.packed_word, '0);
                end else begin
                    want = pending_words.pop_front();
                    if (word_ch.packed_word !== want.word)
                        report_mismatch("packed_word", word_ch.packed_word, want.word);
                    if (word_ch.last_of_line !== want.lol)
                        report_mismatch("last_of_line", 32'(word_ch.last_of_line),
                                        32'(want.lol));
                    if (word_ch.last_of_frame !== want.lof)
                        report_mismatch("last_of_frame", 32'(word_ch.last_of_frame),
                                        32'(want.lof));
                end
            end
        end
    end

    // stimulus
    initial begin
        int k;
        int rand_items;
        int phase_len;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.luma_first  = '0;
        pix_ch.luma_second = '0;
        pix_ch.chroma_blue = '0;
        pix_ch.chroma_red  = '0;
        quiet              = 1'b0;
        cur_typed          = 1'b0;
        cur_typed_word     = '0;
        err_count          = 0;
        cycle_count        = 0;

        // reset values of registers and state
        cfg_depth     = 1'b0;
        cfg_mode      = MODE_422;
        cfg_width     = DIM_W'(1920);
        cfg_height    = DIM_W'(1080);
        pend_acc      = '0;
        pend_cnt      = 0;
        pair_idx      = '0;
        words_in_line = '0;
        line_idx      = '0;
        for (k = 0; k < MAX_WIDTH; k++) chroma_store[k] = '0;

        // directed rows: extremes at reset settings, then each special case
        dir_rows[0]  = pair_row(10'h000, 10'h000, 10'h000, 10'h000, 1'b1, 32'h00401004);
        dir_rows[1]  = pair_row(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b0, '0);
        dir_rows[2]  = pair_row(10'd3, 10'd1020, 10'd4, 10'd1019, 1'b0, '0);
        // width shrunk mid-line
        dir_rows[3]  = reg_row(REG_FRAME_WIDTH, 32'd2);
        dir_rows[4]  = pair_row(10'h155, 10'h2AA, 10'h0F0, 10'h30F, 1'b0, '0);
        dir_rows[5]  = pair_row(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 32'h3FBFEFFB);
        // height of zero
        dir_rows[6]  = reg_row(REG_FRAME_HEIGHT, 32'd0);
        dir_rows[7]  = pair_row(10'h200, 10'h1FF, 10'h3FE, 10'h001, 1'b0, '0);
        // 8-bit samples, low byte only
        dir_rows[8]  = reg_row(REG_SAMPLE_DEPTH, 32'd1);
        dir_rows[9]  = pair_row(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 32'h3F8FE3F8);
        dir_rows[10] = pair_row(10'h301, 10'h0FE, 10'h300, 10'h100, 1'b1, 32'h00401004);
        // width of zero
        dir_rows[11] = reg_row(REG_FRAME_WIDTH, 32'd0);
        dir_rows[12] = pair_row(10'h0AA, 10'h355, 10'h2CC, 10'h133, 1'b0, '0);
        // width and height beyond the limits, then shrunk to end the line
        dir_rows[13] = reg_row(REG_FRAME_WIDTH, 32'h1FFF);
        dir_rows[14] = reg_row(REG_FRAME_HEIGHT, 32'h1FFF);
        dir_rows[15] = pair_row(10'h012, 10'h3ED, 10'h2B4, 10'h14B, 1'b0, '0);
        dir_rows[16] = pair_row(10'h001, 10'h002, 10'h3FD, 10'h3FE, 1'b0, '0);
        dir_rows[17] = pair_row(10'h0FF, 10'h100, 10'h1FF, 10'h200, 1'b0, '0);
        dir_rows[18] = reg_row(REG_FRAME_WIDTH, 32'd4);
        dir_rows[19] = pair_row(10'h3C3, 10'h03C, 10'h1E1, 10'h21E, 1'b0, '0);
        // unused chroma mode
        dir_rows[20] = reg_row(REG_CHROMA_MODE, 32'(MODE_UNUSED));
        dir_rows[21] = pair_row(10'h0F1, 10'h10E, 10'h2D2, 10'h12D, 1'b0, '0);
        dir_rows[22] = pair_row(10'h005, 10'h3FA, 10'h06A, 10'h395, 1'b0, '0);
        // progressive 4:2:0 with 10-bit samples: write line then reuse line
        dir_rows[23] = reg_row(REG_CHROMA_MODE, 32'(MODE_420P));
        dir_rows[24] = reg_row(REG_SAMPLE_DEPTH, 32'd0);
        dir_rows[25] = reg_row(REG_FRAME_HEIGHT, 32'd8);
        dir_rows[26] = pair_row(10'h111, 10'h222, 10'h333, 10'h044, 1'b0, '0);
        dir_rows[27] = pair_row(10'h155, 10'h0AA, 10'h2BB, 10'h3CC, 1'b0, '0);
        dir_rows[28] = pair_row(10'h200, 10'h100, 10'h3FF, 10'h3FF, 1'b0, '0);
        dir_rows[29] = pair_row(10'h080, 10'h040, 10'h000, 10'h000, 1'b0, '0);
        // interlaced 4:2:0, reuse line reaching a never written entry
        dir_rows[30] = reg_row(REG_CHROMA_MODE, 32'(MODE_420I));
        dir_rows[31] = reg_row(REG_FRAME_WIDTH, 32'd2);
        dir_rows[32] = pair_row(10'h1F0, 10'h20F, 10'h2A0, 10'h15F, 1'b0, '0);
        dir_rows[33] = pair_row(10'h300, 10'h0C0, 10'h3E0, 10'h01F, 1'b0, '0);
        dir_rows[34] = reg_row(REG_FRAME_WIDTH, 32'd6);
        dir_rows[35] = pair_row(10'h123, 10'h321, 10'h3FF, 10'h000, 1'b0, '0);
        dir_rows[36] = pair_row(10'h246, 10'h135, 10'h000, 10'h3FF, 1'b0, '0);
        dir_rows[37] = pair_row(10'h0F0, 10'h00F, 10'h155, 10'h2AA, 1'b0, '0);

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_REG) begin
                write_reg_idle(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_pair(dir_rows[k].y0, dir_rows[k].y1, dir_rows[k].cb, dir_rows[k].cr,
                          dir_rows[k].typed, dir_rows[k].typed_word);
            end
        end

        // random phases, each under new settings, quiet at the end
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items + QUIET_ITEMS >= RANDOM_ITEMS) quiet = 1'b1;
            reconfigure_random();
            phase_len = $urandom_range(4, 30);
            repeat (phase_len)
                send_pair(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                          1'b0, '0);
            rand_items += phase_len;
        end

        // drain and finish
        pix_ch.valid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("v210_line_packer_unit: match");
        end else begin
            $display("v210_line_packer_unit: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vlp_pkg.sv
rtl/vlp_pix_if.sv
rtl/vlp_word_if.sv
rtl/vlp_cfg_regs.sv
rtl/vlp_front.sv
rtl/vlp_fifo.sv
rtl/vlp_back.sv
rtl/v210_line_packer_unit.sv
rtl/vlp_checker.sv
dv/v210_line_packer_unit_tb.sv
